// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the interpolation table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition implies the property in the same cycle.
`define TLI_ASSERT_IMPL(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("same-cycle assertion failed");

// The condition implies the property in the following cycle.
`define TLI_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("next-cycle assertion failed");

`else

`define TLI_ASSERT_IMPL(name, clk, rst_n, cond, prop)
`define TLI_ASSERT_NEXT(name, clk, rst_n, cond, prop)

`endif

`endif

// ===== hdl/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg
// Types, sizes and codes of the time series interpolation table.
// ----------------------------------------------------------------------------
package tli_pkg;

	localparam int SLOTS   = 8;
	localparam int POINTS  = 64;
	localparam int KINDS   = 2;
	localparam int SERIES  = KINDS * SLOTS;
	localparam int DEPTH   = SERIES * POINTS;

	localparam int SER_W   = $clog2(SERIES);
	localparam int CNT_W   = $clog2(POINTS + 1);
	localparam int ADDR_W  = $clog2(DEPTH);

	localparam int TIME_W  = 48;
	localparam int VAL_W   = 40;
	localparam int FRAC_W  = 32;
	localparam int RATIO_W = FRAC_W + 1;
	localparam int STEP_W  = $clog2(RATIO_W);

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_CLEAR  = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] KIND_LEVEL     = 2'd0;
	localparam logic [1:0] KIND_DISCHARGE = 2'd1;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_NODATA = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]              command;
		logic [1:0]              series_kind;
		logic [2:0]              slot;
		logic [TIME_W-1:0]       point_time;
		logic signed [VAL_W-1:0] point_value;
		logic [TIME_W-1:0]       query_time;
	} tli_in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [1:0]              status;
	} tli_out_word_t;

	typedef struct packed {
		logic [TIME_W-1:0]       pt_time;
		logic signed [VAL_W-1:0] pt_value;
	} tli_point_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tli_unit_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMD,
		S_SCAN,
		S_DIV,
		S_MUL,
		S_RESP
	} tli_state_t;

endpackage

// ===== hdl/tli_divider.sv =====
// ----------------------------------------------------------------------------
// tli_divider
// Serial restoring divider giving floor(num * 2^32 / den), one bit per cycle.
// ----------------------------------------------------------------------------
module tli_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tli_pkg::TIME_W-1:0]  num,
	input  logic [tli_pkg::TIME_W-1:0]  den,
	output logic [tli_pkg::RATIO_W-1:0] quo,
	output tli_pkg::tli_unit_stat_t     stat
);

	logic                        busy_q;
	logic                        done_q;
	logic [tli_pkg::STEP_W-1:0]  step_q;
	logic [tli_pkg::TIME_W-1:0]  rem_q;
	logic [tli_pkg::TIME_W-1:0]  den_q;
	logic [tli_pkg::RATIO_W-1:0] quo_q;

	logic [tli_pkg::TIME_W:0]    shifted;
	logic                        ge;
	logic [tli_pkg::TIME_W:0]    rem_n;

	// The first step compares without a shift to form the integer bit.
	always_comb begin
		shifted = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
		ge      = shifted >= {1'b0, den_q};
		rem_n   = ge ? shifted - {1'b0, den_q} : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == tli_pkg::STEP_W'(tli_pkg::FRAC_W)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n[tli_pkg::TIME_W-1:0];
			quo_q <= {quo_q[tli_pkg::RATIO_W-2:0], ge};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hdl/tli_scale.sv =====
// ----------------------------------------------------------------------------
// tli_scale
// Three-stage pipeline applying a Q1.32 ratio to the step between two values.
// ----------------------------------------------------------------------------
module tli_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tli_pkg::RATIO_W-1:0]       ratio,
	input  logic signed [tli_pkg::VAL_W-1:0]  low_value,
	input  logic signed [tli_pkg::VAL_W-1:0]  high_value,
	output logic signed [tli_pkg::VAL_W-1:0]  result,
	output tli_pkg::tli_unit_stat_t           stat
);

	localparam int MAG_W  = tli_pkg::VAL_W;
	localparam int HI_W   = MAG_W - tli_pkg::FRAC_W;
	localparam int PHI_W  = tli_pkg::RATIO_W + HI_W;
	localparam int PLO_W  = tli_pkg::RATIO_W + tli_pkg::FRAC_W;
	localparam int M_W    = tli_pkg::VAL_W + 2;

	logic vld_s1, vld_s2, vld_s3;

	logic signed [tli_pkg::VAL_W:0]   delta;
	logic [tli_pkg::VAL_W:0]          mag_full;

	logic                             neg_s1;
	logic [MAG_W-1:0]                 mag_s1;
	logic signed [tli_pkg::VAL_W-1:0] vl_s1;
	logic [tli_pkg::RATIO_W-1:0]      ratio_s1;

	logic                             neg_s2;
	logic [PHI_W-1:0]                 prod_hi_s2;
	logic [PLO_W-1:0]                 prod_lo_s2;
	logic signed [tli_pkg::VAL_W-1:0] vl_s2;

	logic [PLO_W-1:0]                 rnd;
	logic [M_W-1:0]                   m;
	logic [M_W-1:0]                   vl_ext;
	logic [M_W-1:0]                   sum;

	logic signed [tli_pkg::VAL_W-1:0] result_s3;

	always_comb begin
		delta    = {high_value[tli_pkg::VAL_W-1], high_value}
		         - {low_value[tli_pkg::VAL_W-1], low_value};
		mag_full = delta[tli_pkg::VAL_W] ? -delta : delta;
		rnd      = prod_lo_s2 + PLO_W'(64'd1 << (tli_pkg::FRAC_W - 1));
		m        = M_W'(prod_hi_s2) + M_W'(rnd[PLO_W-1:tli_pkg::FRAC_W]);
		vl_ext   = {{(M_W - tli_pkg::VAL_W){vl_s2[tli_pkg::VAL_W-1]}}, vl_s2};
		sum      = neg_s2 ? vl_ext - m : vl_ext + m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_s1   <= delta[tli_pkg::VAL_W];
			mag_s1   <= mag_full[MAG_W-1:0];
			vl_s1    <= low_value;
			ratio_s1 <= ratio;
		end
		if (vld_s1) begin
			neg_s2     <= neg_s1;
			vl_s2      <= vl_s1;
			prod_hi_s2 <= PHI_W'(ratio_s1) * PHI_W'(mag_s1[MAG_W-1:tli_pkg::FRAC_W]);
			prod_lo_s2 <= PLO_W'(ratio_s1) * PLO_W'(mag_s1[tli_pkg::FRAC_W-1:0]);
		end
		if (vld_s2) begin
			result_s3 <= sum[tli_pkg::VAL_W-1:0];
		end
	end

	assign result    = result_s3;
	assign stat.busy = vld_s1 | vld_s2;
	assign stat.done = vld_s3;

endmodule

// ===== hdl/timeseries_linear_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// timeseries_linear_interpolator_core
// Boundary time series tables with linear interpolation between points.
//
// One word in, one word out. An append or a clear, or a word for another
// kind, passes through the command and response states before its result
// is registered at the output. A query on a non-empty series scans it from
// the first point, one point a cycle. When the query falls between two
// points it goes on to the serial divider, which loads its operands and
// then forms the 33-bit interpolation ratio one bit a cycle, and then to
// the multiply pipeline. The block takes a new word only when the
// previous one has been worked through; a finished result waits in the
// output register.
// The point store holds no reset state and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timeseries_linear_interpolator_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tli_pkg::tli_in_word_t  in_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tli_pkg::tli_out_word_t out_word
);

	tli_pkg::tli_state_t         state_q, state_d;
	tli_pkg::tli_in_word_t       item_q;
	logic [tli_pkg::CNT_W-1:0]   counts_q [tli_pkg::SERIES];

	tli_pkg::tli_point_t         mem_q [tli_pkg::DEPTH];
	tli_pkg::tli_point_t         rd_data_s1;
	logic                        rd_vld_s1;
	logic [tli_pkg::CNT_W-1:0]   chk_idx_s1;
	logic [tli_pkg::CNT_W-1:0]   rd_idx_q;

	tli_pkg::tli_point_t         prev_q;
	tli_pkg::tli_point_t         upper_q;
	logic signed [tli_pkg::VAL_W-1:0] res_value_q;
	logic [1:0]                  res_status_q;

	logic                        out_valid_q;
	tli_pkg::tli_out_word_t      out_word_q;

	logic                        kind_ok, cmd_ok, slot_ok, sel_ok;
	logic [tli_pkg::SER_W-1:0]   ser_idx;
	logic [tli_pkg::CNT_W-1:0]   cnt_cur;
	logic [tli_pkg::ADDR_W-1:0]  base_addr, rd_addr, wr_addr;
	logic                        has_room;

	logic                        hit, last, scan_end, need_div;
	logic                        issue, div_start, scl_start, out_load;

	logic [tli_pkg::RATIO_W-1:0] ratio;
	tli_pkg::tli_unit_stat_t     div_stat;
	tli_pkg::tli_unit_stat_t     scl_stat;
	logic signed [tli_pkg::VAL_W-1:0] scl_result;

	always_comb begin
		kind_ok  = (item_q.series_kind == tli_pkg::KIND_LEVEL)
		        || (item_q.series_kind == tli_pkg::KIND_DISCHARGE);
		cmd_ok   = (item_q.command == tli_pkg::CMD_APPEND)
		        || (item_q.command == tli_pkg::CMD_CLEAR)
		        || (item_q.command == tli_pkg::CMD_QUERY);
		slot_ok  = int'(item_q.slot) < tli_pkg::SLOTS;
		sel_ok   = kind_ok && cmd_ok && slot_ok;
		ser_idx  = (item_q.series_kind == tli_pkg::KIND_DISCHARGE)
		         ? tli_pkg::SER_W'(tli_pkg::SLOTS) + tli_pkg::SER_W'(item_q.slot)
		         : tli_pkg::SER_W'(item_q.slot);
		cnt_cur  = sel_ok ? counts_q[ser_idx] : '0;
		has_room = cnt_cur < tli_pkg::CNT_W'(tli_pkg::POINTS);
		base_addr = tli_pkg::ADDR_W'(int'(ser_idx) * tli_pkg::POINTS);
		rd_addr  = base_addr + tli_pkg::ADDR_W'(rd_idx_q);
		wr_addr  = base_addr + tli_pkg::ADDR_W'(cnt_cur);

		hit      = rd_vld_s1 && (rd_data_s1.pt_time >= item_q.query_time);
		last     = rd_vld_s1 && !hit
		        && (chk_idx_s1 == cnt_cur - tli_pkg::CNT_W'(1));
		scan_end = hit || last;
		need_div = hit && (chk_idx_s1 != '0) && (rd_data_s1.pt_time > prev_q.pt_time);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tli_pkg::S_IDLE: begin
				if (in_valid) state_d = tli_pkg::S_CMD;
			end
			tli_pkg::S_CMD: begin
				if (sel_ok && item_q.command == tli_pkg::CMD_QUERY && cnt_cur != '0)
					state_d = tli_pkg::S_SCAN;
				else
					state_d = tli_pkg::S_RESP;
			end
			tli_pkg::S_SCAN: begin
				if (need_div)      state_d = tli_pkg::S_DIV;
				else if (scan_end) state_d = tli_pkg::S_RESP;
			end
			tli_pkg::S_DIV: begin
				if (div_stat.done) state_d = tli_pkg::S_MUL;
			end
			tli_pkg::S_MUL: begin
				if (scl_stat.done) state_d = tli_pkg::S_RESP;
			end
			tli_pkg::S_RESP: begin
				if (!out_valid_q || out_ready) state_d = tli_pkg::S_IDLE;
			end
			default: state_d = tli_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		issue     = 1'b0;
		div_start = 1'b0;
		scl_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			tli_pkg::S_IDLE: in_ready  = 1'b1;
			tli_pkg::S_SCAN: begin
				issue     = (rd_idx_q < cnt_cur) && !scan_end;
				div_start = need_div;
			end
			tli_pkg::S_DIV:  scl_start = div_stat.done;
			tli_pkg::S_RESP: out_load  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tli_pkg::S_IDLE;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < tli_pkg::SERIES; i++) counts_q[i] <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (state_q == tli_pkg::S_CMD) begin
				rd_idx_q <= '0;
				if (sel_ok && item_q.command == tli_pkg::CMD_APPEND && has_room)
					counts_q[ser_idx] <= cnt_cur + 1'b1;
				if (sel_ok && item_q.command == tli_pkg::CMD_CLEAR)
					counts_q[ser_idx] <= '0;
			end
			if (issue) rd_idx_q <= rd_idx_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_word;
		if (state_q == tli_pkg::S_CMD && sel_ok && item_q.command == tli_pkg::CMD_APPEND
				&& has_room) begin
			mem_q[wr_addr] <= '{pt_time: item_q.point_time, pt_value: item_q.point_value};
		end
		if (issue) begin
			rd_data_s1 <= mem_q[rd_addr];
			chk_idx_s1 <= rd_idx_q;
		end
		if (state_q == tli_pkg::S_CMD) begin
			res_value_q <= '0;
			if (!sel_ok)
				res_status_q <= tli_pkg::ST_NODATA;
			else if (item_q.command == tli_pkg::CMD_APPEND)
				res_status_q <= has_room ? tli_pkg::ST_DONE : tli_pkg::ST_FULL;
			else if (item_q.command == tli_pkg::CMD_CLEAR)
				res_status_q <= tli_pkg::ST_DONE;
			else
				res_status_q <= (cnt_cur == '0) ? tli_pkg::ST_NODATA : tli_pkg::ST_DONE;
		end
		if (state_q == tli_pkg::S_SCAN && rd_vld_s1) begin
			if (!hit) prev_q <= rd_data_s1;
			else      upper_q <= rd_data_s1;
			if (scan_end && !need_div) res_value_q <= rd_data_s1.pt_value;
		end
		if (state_q == tli_pkg::S_MUL && scl_stat.done) res_value_q <= scl_result;
		if (out_load) begin
			out_word_q.result_value <= res_value_q;
			out_word_q.status       <= res_status_q;
		end
	end

	tli_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (item_q.query_time - prev_q.pt_time),
		.den    (rd_data_s1.pt_time - prev_q.pt_time),
		.quo    (ratio),
		.stat   (div_stat)
	);

	tli_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scl_start),
		.ratio      (ratio),
		.low_value  (prev_q.pt_value),
		.high_value (upper_q.pt_value),
		.result     (scl_result),
		.stat       (scl_stat)
	);

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`TLI_ASSERT_IMPL(a_ready_units_idle, clk, arst_n, in_ready, !div_stat.busy && !scl_stat.busy)
	`TLI_ASSERT_IMPL(a_div_done_in_div, clk, arst_n, div_stat.done, state_q == tli_pkg::S_DIV)
	`TLI_ASSERT_NEXT(a_div_then_mul, clk, arst_n, div_stat.done, state_q == tli_pkg::S_MUL)
	`TLI_ASSERT_IMPL(a_count_bound, clk, arst_n, state_q == tli_pkg::S_CMD, cnt_cur <= tli_pkg::CNT_W'(tli_pkg::POINTS))

endmodule
